// ===== src/assert_macros.svh =====
// assertion macros used by the top level rtl file
// clock clk_i and active-low reset rst_ni are assumed in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ON(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== src/mbmt_pkg.sv =====
// shared types and constants of the modular byte matrix transform
// no dependencies
package mbmt_pkg;

  localparam int unsigned POINTS    = 8;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = POINTS * BYTE_W;
  localparam int unsigned ACC_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned ROW_SEL_W = $clog2(POINTS);

  // index of the first matrix row register, rows follow in order
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROW_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = CFG_IDX_W'(POINTS);

  typedef logic [WORD_W-1:0]               word_t;
  typedef logic [BYTE_W-1:0]               byte_t;
  typedef logic [ACC_W-1:0]                acc_t;
  typedef logic [CFG_IDX_W-1:0]            cfg_idx_t;
  typedef logic [POINTS-1:0][WORD_W-1:0]   rows_t;
  typedef logic [POINTS-1:0][ACC_W-1:0]    sums_t;

endpackage

// ===== src/modular_byte_matrix_transform_top.sv =====
// top level of the modular byte matrix transform: matrix registers,
// column dot products and result register; depends on mbmt_pkg, mbmt_reduce
//
// done_o rises with word_out_o once the word has passed the input, column sum,
// quotient and result registers in that order
// throughput: one word per cycle, busy_o stays low; results cannot be stalled
// reset: rst_ni clears the matrix rows to zero and empties the pipeline
`include "assert_macros.svh"

module modular_byte_matrix_transform_top #(
  parameter int unsigned MODULUS = 127
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  mbmt_pkg::word_t    word_in_i,
  output logic               done_o,
  output mbmt_pkg::word_t    word_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  mbmt_pkg::cfg_idx_t cfg_idx_i,
  input  mbmt_pkg::word_t    cfg_data_i
);
  import mbmt_pkg::*;

  rows_t    rows_q;
  word_t    word_q;
  sums_t    sum_d, sum_q;
  word_t    res_d, res_q;
  logic     in_v_q, sum_v_q, quot_v_q, done_q;
  logic     accept;
  cfg_idx_t row_off;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign row_off     = cfg_idx_i - CFG_MATRIX_ROW_0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_idx_i < CFG_ROW_COUNT)) begin
      rows_q[row_off[ROW_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      sum_v_q  <= 1'b0;
      quot_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_v_q   <= accept;
      sum_v_q  <= in_v_q;
      quot_v_q <= sum_v_q;
      done_q   <= quot_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_in_i;
    end
    sum_q <= sum_d;
    res_q <= res_d;
  end

  // column j: sum of byte i times entry [i][j], wrapping at 16 bits
  always_comb begin
    acc_t acc;
    for (int j = 0; j < POINTS; j++) begin
      acc = '0;
      for (int i = 0; i < POINTS; i++) begin
        acc = acc + ACC_W'(word_q[i*BYTE_W +: BYTE_W]) *
                    ACC_W'(rows_q[i][j*BYTE_W +: BYTE_W]);
      end
      sum_d[j] = acc;
    end
  end

  for (genvar j = 0; j < POINTS; j++) begin : g_col
    mbmt_reduce #(
      .Modulus(MODULUS)
    ) u_reduce (
      .clk_i (clk_i),
      .sum_i (sum_q[j]),
      .rem_o (res_d[j*BYTE_W +: BYTE_W])
    );
  end

  assign done_o     = done_q;
  assign word_out_o = res_q;

  `ASSERT_ON(a_result_follows, accept |-> ##4 done_o, "accepted word gave no result")
  `ASSERT_ON(a_no_spurious, done_o |-> $past(accept, 4), "result without an accepted word")
  `ASSERT_ON(a_bad_idx_ignored, (cfg_valid_i && cfg_idx_i >= CFG_ROW_COUNT) |=> $stable(rows_q),
             "write beyond the row registers changed the matrix")

endmodule

// ===== src/mbmt_reduce.sv =====
// reduces one 16-bit column sum modulo a constant by reciprocal multiplication
// one register stage inside; depends on mbmt_pkg
module mbmt_reduce #(
  parameter int unsigned Modulus = 127
) (
  input  logic           clk_i,
  input  mbmt_pkg::acc_t sum_i,
  output mbmt_pkg::byte_t rem_o
);
  import mbmt_pkg::*;

  localparam int unsigned RecipShift = ACC_W + BYTE_W;
  localparam int unsigned ProdW      = ACC_W + RecipShift;
  localparam longint unsigned RecipVal =
    ((64'd1 << RecipShift) + 64'(Modulus) - 64'd1) / 64'(Modulus);
  localparam logic [RecipShift-1:0] RecipC = RecipShift'(RecipVal);
  localparam acc_t ModC = ACC_W'(Modulus);

  logic [ProdW-1:0] prod;
  acc_t             quot_d, quot_q;
  acc_t             sum_hold_q;
  acc_t             back;
  acc_t             rem;

  // quotient is exact for every 16-bit sum since the shift covers 16 + 8 bits
  assign prod   = {{(ProdW-ACC_W){1'b0}}, sum_i} * {{(ProdW-RecipShift){1'b0}}, RecipC};
  assign quot_d = prod[ProdW-1 -: ACC_W];

  always_ff @(posedge clk_i) begin
    quot_q     <= quot_d;
    sum_hold_q <= sum_i;
  end

  assign back  = quot_q * ModC;
  assign rem   = sum_hold_q - back;
  assign rem_o = rem[BYTE_W-1:0];

endmodule

// ===== tb/sv/tb_modular_byte_matrix_transform_top.sv =====
// testbench for modular_byte_matrix_transform_top: directed and random words checked
// against a behavioral column-sum predictor; depends on mbmt_pkg and the top level rtl
`timescale 1ns / 1ps

module tb_modular_byte_matrix_transform_top;
  import mbmt_pkg::*;

  localparam int unsigned MODULUS      = 127;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_WORDS  = 475;
  localparam int unsigned WORDS_PER_MATRIX = 95;
  localparam cfg_idx_t    CFG_IDX_TOP  = '1;

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  word_t    word_in_i;
  logic     done_o;
  word_t    word_out_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  cfg_idx_t cfg_idx_i;
  word_t    cfg_data_i;

  rows_t       matrix_rows;
  word_t       expected_words[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned idle_pct;

  modular_byte_matrix_transform_top #(
    .MODULUS(MODULUS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .word_in_i  (word_in_i),
    .done_o     (done_o),
    .word_out_o (word_out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // column sums wrap at 16 bits before the modular reduction
  function automatic word_t transform_word(word_t w);
    word_t res;
    acc_t  acc;
    res = '0;
    for (int j = 0; j < POINTS; j++) begin
      acc = '0;
      for (int i = 0; i < POINTS; i++) begin
        acc = acc + w[BYTE_W*i +: BYTE_W] * matrix_rows[i][BYTE_W*j +: BYTE_W];
      end
      res[BYTE_W*j +: BYTE_W] = byte_t'((MODULUS == 0) ? acc : acc % MODULUS);
    end
    return res;
  endfunction

  function automatic byte_t extreme_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      default: return 8'h80;
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < POINTS; i++) w[BYTE_W*i +: BYTE_W] = extreme_byte();
      1: w = '1;
      2: w = '0;
      default: ;
    endcase
    return w;
  endfunction

  // results come one per accepted word and cannot be held off
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        $error("word_out: expected none, actual %h", word_out_o);
        error_count++;
      end else begin
        word_t exp_word;
        exp_word = expected_words.pop_front();
        if (word_out_o !== exp_word) begin
          $error("word_out: expected %h, actual %h", exp_word, word_out_o);
          error_count++;
        end
      end
    end
  end

  task automatic send_word(input word_t w);
    int unsigned gap;
    start_i   <= 1'b1;
    word_in_i <= w;
    do @(posedge clk_i); while (busy_o);
    expected_words.push_back(transform_word(w));
    gap = ($urandom_range(1, 100) <= idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // lower start and let every outstanding transaction come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input cfg_idx_t idx_q[$], input word_t data_q[$]);
    for (int k = 0; k < idx_q.size(); k++) begin
      cfg_valid_i <= 1'b1;
      cfg_idx_i   <= idx_q[k];
      cfg_data_i  <= data_q[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx_q[k] < CFG_ROW_COUNT) matrix_rows[idx_q[k] - CFG_MATRIX_ROW_0] = data_q[k];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_matrix(input rows_t rows, input bit add_stray);
    cfg_idx_t idx_q[$];
    word_t    data_q[$];
    drain_results();
    for (int i = 0; i < POINTS; i++) begin
      idx_q.push_back(CFG_MATRIX_ROW_0 + cfg_idx_t'(i));
      data_q.push_back(rows[i]);
    end
    // out-of-range index must leave the rows alone
    if (add_stray) begin
      idx_q.push_back(cfg_idx_t'($urandom_range(CFG_ROW_COUNT, CFG_IDX_TOP)));
      data_q.push_back({$urandom, $urandom});
    end
    write_regs(idx_q, data_q);
  endtask

  task automatic test_reset_matrix();
    send_word('1);
    send_word(64'h0123_4567_89AB_CDEF);
    send_word('0);
  endtask

  task automatic test_identity();
    rows_t rows;
    rows = '0;
    for (int i = 0; i < POINTS; i++) rows[i][BYTE_W*i +: BYTE_W] = 8'h01;
    load_matrix(rows, 1'b0);
    send_word('0);
    send_word('1);
    send_word({POINTS{8'h7F}});
    send_word({POINTS{8'h7E}});
    send_word({POINTS{8'h80}});
    send_word(64'h0102_0408_1020_4080);
    send_word(64'hFE7F_8000_FF7E_0181);
  endtask

  task automatic test_accumulator_wrap();
    rows_t rows;
    rows = '1;
    load_matrix(rows, 1'b0);
    send_word('1);
    send_word(64'hFF00_FF00_FF00_FF00);
    send_word(64'h0000_0000_0000_0101);
  endtask

  task automatic test_stray_index();
    cfg_idx_t idx_q[$];
    word_t    data_q[$];
    drain_results();
    idx_q  = '{CFG_ROW_COUNT, CFG_IDX_TOP, cfg_idx_t'(8'h55)};
    data_q = '{64'h0, 64'h0, 64'h0};
    write_regs(idx_q, data_q);
    send_word('1);
    send_word(64'h8040_2010_0804_0201);
    send_word(64'h7F7F_7F7F_0000_0000);
  endtask

  task automatic test_random_words();
    int unsigned pct_list[4] = '{0, 66, 0, 33};
    rows_t       rows;
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct_list[p];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % WORDS_PER_MATRIX == 0) begin
          for (int i = 0; i < POINTS; i++) begin
            case ($urandom_range(0, 9))
              0: rows[i] = '1;
              1: rows[i] = '0;
              2: for (int j = 0; j < POINTS; j++) rows[i][BYTE_W*j +: BYTE_W] = extreme_byte();
              default: rows[i] = {$urandom, $urandom};
            endcase
          end
          if (n == WORDS_PER_MATRIX && p == 1) rows = '1;
          load_matrix(rows, $urandom_range(0, 2) == 0);
        end
        send_word(random_word());
      end
    end
  endtask

  initial begin
    start_i     <= 1'b0;
    word_in_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    matrix_rows = '0;
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_matrix();
    test_identity();
    test_accumulator_wrap();
    test_stray_index();
    test_random_words();

    drain_results();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mbmt_pkg.sv
src/mbmt_reduce.sv
src/modular_byte_matrix_transform_top.sv
tb/sv/tb_modular_byte_matrix_transform_top.sv
